/* src/bcg_pkg.sv */
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants of the brute-force candidate generator.
// ----------------------------------------------------------------------------
package bcg_pkg;

	localparam int MAX_LEN_DEF       = 16;
	localparam int CHARSET_DEPTH_DEF = 256;
	localparam int CFG_DW            = 9;
	localparam int CMD_DEPTH         = 2;
	localparam int OUT_DEPTH         = 4;

	localparam logic [8:0] SIZE_RST = 9'd1;
	localparam logic [4:0] MIN_RST  = 5'd1;
	localparam logic [4:0] MAX_RST  = 5'd8;

	typedef enum logic [1:0] {
		MODE_LOAD_CHAR  = 2'd0,
		MODE_LOAD_START = 2'd1,
		MODE_BEGIN      = 2'd2,
		MODE_NEXT       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_CHARSET_SIZE = 2'd0,
		CFG_MIN_LENGTH   = 2'd1,
		CFG_MAX_LENGTH   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_LOAD_CHAR   = 3'd0,
		OP_LOAD_START  = 3'd1,
		OP_BEGIN       = 3'd2,
		OP_BEGIN_START = 3'd3,
		OP_NEXT        = 3'd4
	} cmd_op_t;

	typedef enum logic [2:0] {
		BK_IDLE   = 3'd0,
		BK_EMIT   = 3'd1,
		BK_ADV_RD = 3'd2,
		BK_ADV    = 3'd3,
		BK_BEGIN  = 3'd4
	} back_state_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] index;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] character;
		logic [3:0] position;
		logic [4:0] length;
		logic       last;
		logic       exhausted;
	} rsp_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] index;
		logic [7:0] value;
	} cmd_t;

	typedef struct packed {
		logic [8:0] charset_size;
		logic [4:0] min_length;
		logic [4:0] max_length;
	} cfg_t;

endpackage

/* src/bcg_ram.sv */
// ----------------------------------------------------------------------------
// bcg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bcg_pkg::CHARSET_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/bcg_fifo.sv */
// ----------------------------------------------------------------------------
// bcg_fifo
// Small register FIFO with occupancy count, used between front and back
// and as the result buffer.
// ----------------------------------------------------------------------------
module bcg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bcg_pkg::CMD_DEPTH,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full,
	output logic [CW-1:0]    count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

/* src/bcg_front.sv */
// ----------------------------------------------------------------------------
// bcg_front
// Input stage: takes request words, drops out-of-range loads and turns the
// rest into commands for the back end.
// ----------------------------------------------------------------------------
module bcg_front #(
	parameter int MAX_LEN       = bcg_pkg::MAX_LEN_DEF,
	parameter int CHARSET_DEPTH = bcg_pkg::CHARSET_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bcg_pkg::req_t req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output bcg_pkg::cmd_t cmd
);

	import bcg_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic keep;

	always_comb begin
		cmd_d.index = req.index;
		cmd_d.value = req.value;
		cmd_d.op    = OP_NEXT;
		keep        = 1'b1;
		unique case (req.mode)
			MODE_LOAD_CHAR: begin
				cmd_d.op = OP_LOAD_CHAR;
				keep     = (32'(req.index) < CHARSET_DEPTH);
			end
			MODE_LOAD_START: begin
				cmd_d.op = OP_LOAD_START;
				keep     = (32'(req.index) < MAX_LEN);
			end
			MODE_BEGIN: begin
				cmd_d.op = req.value[0] ? OP_BEGIN_START : OP_BEGIN;
			end
			MODE_NEXT: begin
				cmd_d.op = OP_NEXT;
			end
		endcase
	end

	assign req_ready = !v_s1 || cmd_ready;
	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* src/bcg_back.sv */
// ----------------------------------------------------------------------------
// bcg_back
// Command executor: owns the character table, the odometer digits and the
// start digits, emits candidates one character per word and advances them.
// ----------------------------------------------------------------------------
module bcg_back #(
	parameter int MAX_LEN       = bcg_pkg::MAX_LEN_DEF,
	parameter int CHARSET_DEPTH = bcg_pkg::CHARSET_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bcg_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  bcg_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bcg_pkg::rsp_t rsp
);

	import bcg_pkg::*;

	localparam int LW  = $clog2(MAX_LEN + 2);
	localparam int LAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CAW = (CHARSET_DEPTH > 1) ? $clog2(CHARSET_DEPTH) : 1;
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	function automatic logic [LW-1:0] eff_len(input logic [4:0] v);
		logic [LW-1:0] r;
		if (v == 5'd0) begin
			r = LW'(1);
		end else if (32'(v) > MAX_LEN) begin
			r = LW'(MAX_LEN);
		end else begin
			r = LW'(v);
		end
		return r;
	endfunction

	back_state_t state_q, state_d;

	logic [8:0]    size_eff;
	logic [LW-1:0] min_eff;
	logic [LW-1:0] max_eff;
	logic          max_lt_min;

	logic [LW-1:0]      len_q;
	logic [LW-1:0]      p_q;
	logic [LW-1:0]      k_q;
	logic [LAW-1:0]     i_q;
	logic               done_q;
	logic               ok_q;
	logic [MAX_LEN-1:0] dvalid_q;
	logic [MAX_LEN-1:0] svalid_q;

	// emit pipeline: digit read, then table read
	logic          v_s1, last_s1, dv_s1;
	logic [LW-1:0] p_s1;
	logic          v_s2, last_s2, inr_s2;
	logic [LW-1:0] p_s2;

	// start-digit copy pipeline
	logic           bv_s1, bsv_s1;
	logic [LAW-1:0] bk_s1;

	// memory ports
	logic           cs_we;
	logic [CAW-1:0] cs_waddr, cs_raddr;
	logic [7:0]     cs_wdata, cs_rdata;
	logic           dig_we;
	logic [LAW-1:0] dig_waddr, dig_raddr;
	logic [7:0]     dig_wdata, dig_rdata;
	logic           st_we;
	logic [LAW-1:0] st_waddr, st_raddr;
	logic [7:0]     st_wdata, st_rdata;

	// control
	logic          issue, b_issue;
	logic          emit_go, begin_go, begin_fin;
	logic          adv_inc, adv_clr, adv_carry;
	logic          out_push, out_full, out_empty;
	logic [OCW-1:0] out_count;
	logic [OCW:0]   occ;
	logic          credit_ok;
	rsp_t          out_wdata;
	logic [$bits(rsp_t)-1:0] out_rdata;

	logic [7:0]    d_cur, d1, sd;
	logic [8:0]    d_next;
	logic [LW-1:0] nlen;
	logic          len_over;

	always_comb begin
		if (cfg.charset_size == 9'd0) begin
			size_eff = 9'd1;
		end else if (32'(cfg.charset_size) > CHARSET_DEPTH) begin
			size_eff = 9'(CHARSET_DEPTH);
		end else begin
			size_eff = cfg.charset_size;
		end
	end

	assign min_eff    = eff_len(cfg.min_length);
	assign max_eff    = eff_len(cfg.max_length);
	assign max_lt_min = (max_eff < min_eff);

	assign d_cur    = dvalid_q[i_q] ? dig_rdata : 8'd0;
	assign d_next   = {1'b0, d_cur} + 9'd1;
	assign d1       = dv_s1 ? dig_rdata : 8'd0;
	assign cs_raddr = CAW'(d1);
	assign sd       = bsv_s1 ? st_rdata : 8'd0;
	assign nlen     = len_q + 1'b1;
	assign len_over = (nlen > max_eff) || (32'(nlen) > MAX_LEN);

	// words in the result buffer plus those still in the read pipeline
	assign occ       = {1'b0, out_count} + (OCW + 1)'(v_s1) + (OCW + 1)'(v_s2);
	assign credit_ok = (occ < (OCW + 1)'(OUT_DEPTH));

	assign b_issue = (state_q == BK_BEGIN) && (k_q != len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		issue     = 1'b0;
		emit_go   = 1'b0;
		begin_go  = 1'b0;
		begin_fin = 1'b0;
		adv_inc   = 1'b0;
		adv_clr   = 1'b0;
		adv_carry = 1'b0;
		out_push  = 1'b0;
		out_wdata = '0;
		cs_we     = 1'b0;
		cs_waddr  = CAW'(cmd.index);
		cs_wdata  = cmd.value;
		st_we     = 1'b0;
		st_waddr  = LAW'(cmd.index);
		st_wdata  = cmd.value;
		st_raddr  = LAW'(k_q);
		dig_we    = 1'b0;
		dig_waddr = i_q;
		dig_wdata = 8'd0;
		dig_raddr = LAW'(p_q);

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op) inside
						OP_LOAD_CHAR: begin
							cs_we   = 1'b1;
							cmd_pop = 1'b1;
						end
						OP_LOAD_START: begin
							st_we   = 1'b1;
							cmd_pop = 1'b1;
						end
						OP_BEGIN, OP_BEGIN_START: begin
							begin_go = 1'b1;
							cmd_pop  = 1'b1;
							if (!max_lt_min && (cmd.op == OP_BEGIN_START)) begin
								state_d = BK_BEGIN;
							end
						end
						OP_NEXT: begin
							if (done_q) begin
								if (!out_full) begin
									out_push            = 1'b1;
									out_wdata.last      = 1'b1;
									out_wdata.exhausted = 1'b1;
									cmd_pop             = 1'b1;
								end
							end else begin
								emit_go = 1'b1;
								cmd_pop = 1'b1;
								state_d = BK_EMIT;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			BK_EMIT: begin
				if (p_q != len_q) begin
					issue = credit_ok;
				end else if (!v_s1 && !v_s2) begin
					state_d = BK_ADV_RD;
				end
			end
			BK_ADV_RD: begin
				dig_raddr = LAW'(len_q - 1'b1);
				state_d   = BK_ADV;
			end
			BK_ADV: begin
				// read the next digit to the left while this one settles
				dig_raddr = i_q - 1'b1;
				if (d_next < size_eff) begin
					dig_we    = 1'b1;
					dig_wdata = d_next[7:0];
					adv_inc   = 1'b1;
					state_d   = BK_IDLE;
				end else begin
					adv_clr = 1'b1;
					if (i_q == '0) begin
						adv_carry = 1'b1;
						state_d   = BK_IDLE;
					end
				end
			end
			BK_BEGIN: begin
				if (bv_s1) begin
					dig_we    = 1'b1;
					dig_waddr = bk_s1;
					dig_wdata = sd;
				end
				if ((k_q == len_q) && !bv_s1) begin
					begin_fin = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		if (v_s2) begin
			out_push            = 1'b1;
			out_wdata.character = inr_s2 ? cs_rdata : 8'd0;
			out_wdata.position  = 4'(p_s2);
			out_wdata.length    = 5'(len_q);
			out_wdata.last      = last_s2;
			out_wdata.exhausted = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LW'(1);
			done_q   <= 1'b1;
			p_q      <= '0;
			k_q      <= '0;
			i_q      <= '0;
			ok_q     <= 1'b0;
			dvalid_q <= '0;
			svalid_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			bv_s1    <= 1'b0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			bv_s1 <= b_issue;

			if (st_we) begin
				svalid_q[st_waddr] <= 1'b1;
			end

			if (begin_go) begin
				len_q    <= min_eff;
				done_q   <= max_lt_min;
				dvalid_q <= '0;
				k_q      <= '0;
				ok_q     <= 1'b1;
			end

			if (emit_go) begin
				p_q <= '0;
			end else if (issue) begin
				p_q <= p_q + 1'b1;
			end

			if (b_issue) begin
				k_q <= k_q + 1'b1;
			end
			if (bv_s1) begin
				dvalid_q[bk_s1] <= 1'b1;
				if ({1'b0, sd} >= size_eff) begin
					ok_q <= 1'b0;
				end
			end
			// a bad start digit anywhere means the run starts from zeros
			if (begin_fin && !ok_q) begin
				dvalid_q <= '0;
			end

			if (state_q == BK_ADV_RD) begin
				i_q <= LAW'(len_q - 1'b1);
			end else if ((state_q == BK_ADV) && adv_clr) begin
				i_q <= i_q - 1'b1;
			end
			if (adv_inc) begin
				dvalid_q[i_q] <= 1'b1;
			end
			if (adv_clr) begin
				dvalid_q[i_q] <= 1'b0;
			end
			if (adv_carry) begin
				dvalid_q <= '0;
				if (len_over) begin
					done_q <= 1'b1;
					len_q  <= max_eff;
				end else begin
					len_q <= nlen;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			p_s1    <= p_q;
			last_s1 <= (p_q == (len_q - 1'b1));
			dv_s1   <= dvalid_q[LAW'(p_q)];
		end
		p_s2    <= p_s1;
		last_s2 <= last_s1;
		inr_s2  <= (32'(d1) < CHARSET_DEPTH);
		bk_s1   <= LAW'(k_q);
		bsv_s1  <= svalid_q[LAW'(k_q)];
	end

	bcg_ram #(
		.WIDTH(8),
		.DEPTH(CHARSET_DEPTH)
	) u_charset (
		.clk  (clk),
		.we   (cs_we),
		.waddr(cs_waddr),
		.wdata(cs_wdata),
		.raddr(cs_raddr),
		.rdata(cs_rdata)
	);

	bcg_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_digits (
		.clk  (clk),
		.we   (dig_we),
		.waddr(dig_waddr),
		.wdata(dig_wdata),
		.raddr(dig_raddr),
		.rdata(dig_rdata)
	);

	bcg_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_start (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	bcg_fifo #(
		.WIDTH($bits(rsp_t)),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.pop   (rsp_valid && rsp_ready),
		.rdata (out_rdata),
		.empty (out_empty),
		.full  (out_full),
		.count (out_count)
	);

	assign rsp_valid = !out_empty;
	assign rsp       = out_rdata;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) && (32'(len_q) <= MAX_LEN))
		else $error("candidate length out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result buffer overrun");

	a_emit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> !done_q)
		else $error("emitting while run is exhausted");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("table read without digit read");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_EMIT) |-> !v_s1)
		else $error("emit pipeline busy outside emit");

endmodule

/* src/bruteforce_candidate_generator.sv */
// ----------------------------------------------------------------------------
// bruteforce_candidate_generator
// Enumerates all strings over a loaded character set between two lengths.
// ----------------------------------------------------------------------------
// A request word is registered and classified by the front end, then queued
// (two entries) for the back end, which executes loads, run starts and next
// requests in order and places results in a four-word buffer. A next request
// emits its candidate one character per cycle while the result buffer has
// room, behind two registered RAM reads, digit store then character table;
// the advance that follows walks the single read port of the digit store one
// position per cycle as the carry runs through the digits. Configuration
// writes apply immediately and are meant for idle periods only.
module bruteforce_candidate_generator #(
	parameter int MAX_LEN       = bcg_pkg::MAX_LEN_DEF,
	parameter int CHARSET_DEPTH = bcg_pkg::CHARSET_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bcg_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bcg_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [bcg_pkg::CFG_DW-1:0] cfg_data
);

	import bcg_pkg::*;

	cfg_t cfg_q;
	logic front_valid;
	cmd_t front_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic [$bits(cmd_t)-1:0] q_rdata;
	cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charset_size <= SIZE_RST;
			cfg_q.min_length   <= MIN_RST;
			cfg_q.max_length   <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHARSET_SIZE: cfg_q.charset_size <= cfg_data;
				CFG_MIN_LENGTH:   cfg_q.min_length   <= cfg_data[4:0];
				CFG_MAX_LENGTH:   cfg_q.max_length   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	bcg_front #(
		.MAX_LEN      (MAX_LEN),
		.CHARSET_DEPTH(CHARSET_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(front_valid),
		.cmd_ready(!q_full),
		.cmd      (front_cmd)
	);

	bcg_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_valid && !q_full),
		.wdata (front_cmd),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (q_full),
		.count ()
	);

	assign q_cmd = q_rdata;

	bcg_back #(
		.MAX_LEN      (MAX_LEN),
		.CHARSET_DEPTH(CHARSET_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(!q_empty),
		.cmd      (q_cmd),
		.cmd_pop  (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

/* tb/bcg_candidate_checker.sv */
// ----------------------------------------------------------------------------
// bcg_candidate_checker
// Watches the request, result and register ports of the candidate generator,
// keeps its own copy of the odometer state, predicts the result words of
// every accepted request and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module bcg_candidate_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  bcg_pkg::req_t              req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  bcg_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bcg_pkg::CFG_DW-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bcg_pkg::*;

	logic [7:0] char_tab [CHARSET_DEPTH_DEF];
	logic [7:0] odo [MAX_LEN_DEF];
	logic [7:0] seed_digits [MAX_LEN_DEF];
	int         cur_len;
	bit         run_over;
	logic [8:0] size_reg;
	logic [4:0] min_reg;
	logic [4:0] max_reg;
	rsp_t       due_chars [$];

	function automatic int alphabet();
		if (size_reg == 0) return 1;
		if (size_reg > CHARSET_DEPTH_DEF) return CHARSET_DEPTH_DEF;
		return int'(size_reg);
	endfunction

	function automatic int clamp_len(logic [4:0] v);
		if (v == 0) return 1;
		if (v > MAX_LEN_DEF) return MAX_LEN_DEF;
		return int'(v);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// last position turns fastest; carry out of the first one moves to the next length
	task automatic roll_odometer();
		int size;
		int i;
		int d;
		size = alphabet();
		i = cur_len;
		while (i > 0) begin
			i--;
			d = odo[i] + 1;
			if (d < size) begin
				odo[i] = d[7:0];
				return;
			end
			odo[i] = '0;
		end
		foreach (odo[k]) odo[k] = '0;
		cur_len++;
		if (cur_len > clamp_len(max_reg) || cur_len > MAX_LEN_DEF) begin
			run_over = 1'b1;
			cur_len = clamp_len(max_reg);
		end
	endtask

	task automatic predict_word(req_t w);
		int   lo;
		int   hi;
		int   size;
		int   k;
		int   p;
		bit   use_seed;
		rsp_t r;
		case (w.mode)
			MODE_LOAD_CHAR: begin
				char_tab[w.index] = w.value;
			end
			MODE_LOAD_START: begin
				if (w.index < MAX_LEN_DEF) seed_digits[w.index] = w.value;
			end
			MODE_BEGIN: begin
				lo = clamp_len(min_reg);
				hi = clamp_len(max_reg);
				size = alphabet();
				foreach (odo[j]) odo[j] = '0;
				cur_len = lo;
				if (hi < lo) begin
					run_over = 1'b1;
				end else begin
					run_over = 1'b0;
					use_seed = w.value[0];
					// any seed digit outside the alphabet drops back to all zeros
					for (k = 0; k < lo; k++)
						if (seed_digits[k] >= size) use_seed = 1'b0;
					if (use_seed)
						for (k = 0; k < lo; k++) odo[k] = seed_digits[k];
				end
			end
			MODE_NEXT: begin
				if (run_over) begin
					r = '0;
					r.last = 1'b1;
					r.exhausted = 1'b1;
					due_chars.push_back(r);
				end else begin
					for (p = 0; p < cur_len; p++) begin
						r.character = char_tab[odo[p]];
						r.position = p[3:0];
						r.length = cur_len[4:0];
						r.last = (p + 1 == cur_len);
						r.exhausted = 1'b0;
						due_chars.push_back(r);
					end
					roll_odometer();
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (odo[k]) odo[k] = '0;
			foreach (seed_digits[k]) seed_digits[k] = '0;
			cur_len = 1;
			run_over = 1'b1;
			size_reg = SIZE_RST;
			min_reg = MIN_RST;
			max_reg = MAX_RST;
			due_chars.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHARSET_SIZE: size_reg = cfg_data;
					CFG_MIN_LENGTH:   min_reg = cfg_data[4:0];
					CFG_MAX_LENGTH:   max_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (due_chars.size() == 0) begin
					$error("unexpected result word: character %0d position %0d length %0d",
						rsp.character, rsp.position, rsp.length);
					fail_count++;
				end else begin
					want = due_chars.pop_front();
					check_field("character", want.character, rsp.character);
					check_field("position", want.position, rsp.position);
					check_field("length", want.length, rsp.length);
					check_field("last", want.last, rsp.last);
					check_field("exhausted", want.exhausted, rsp.exhausted);
				end
			end
			if (req_valid && req_ready) predict_word(req);
			pending <= due_chars.size();
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the brute-force candidate generator: a directed opening over
// loads, run starts, empty ranges and exhausted runs, then random phases over
// a range of alphabet sizes and lengths with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bcg_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid;
	logic              req_ready;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	int         fail_count;
	int         pending;
	int         cycles = 0;
	int         alph = 1;
	bit         squeeze = 1'b0;
	bit         send_calm = 1'b0;
	bit         take_calm = 1'b0;
	bit [255:0] table_loaded = '0;

	always #6 clk = ~clk;

	bruteforce_candidate_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bcg_candidate_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random gaps, calm stretches, one long hold-off on request
	initial begin : sink
		int  w;
		bit  held;
		held = 1'b0;
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze && !held) begin
				w = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
				w = take_calm ? 0 : $urandom_range(0, 12);
			end
			if (w > 0) begin
				rsp_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	task automatic send(mode_t m, logic [7:0] idx, logic [7:0] val);
		int w;
		if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
		w = send_calm ? 0 : $urandom_range(0, 12);
		if (w > 0) begin
			req_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		req <= {m, idx, val};
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (m == MODE_LOAD_CHAR) table_loaded[idx] = 1'b1;
	endtask

	// no word in flight and no result owed, then room for a trailing load or begin
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(cfg_idx_t r, int v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[CFG_DW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
		return $urandom_range(0, alph - 1);
	endfunction

	// every table entry the odometer can reach gets written before the size grows
	task automatic configure(int size_v, int min_v, int max_v);
		int lim;
		int e;
		lim = (size_v == 0) ? 1 : ((size_v > 256) ? 256 : size_v);
		for (e = 0; e < lim; e++)
			if (!table_loaded[e]) send(MODE_LOAD_CHAR, e[7:0], $urandom_range(0, 255));
		settle();
		set_reg(CFG_CHARSET_SIZE, size_v);
		set_reg(CFG_MIN_LENGTH, min_v);
		set_reg(CFG_MAX_LENGTH, max_v);
		alph = lim;
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 62)
			send(MODE_NEXT, $urandom_range(0, 255), $urandom_range(0, 255));
		else if (pick < 72)
			send(MODE_BEGIN, $urandom_range(0, 255), $urandom_range(0, 255));
		else if (pick < 84)
			send(MODE_LOAD_START,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15),
				pick_digit());
		else
			send(MODE_LOAD_CHAR, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic run_phase(int size_v, int min_v, int max_v, int count, bit hold);
		int n;
		int k;
		int lo;
		configure(size_v, min_v, max_v);
		lo = (min_v == 0) ? 1 : ((min_v > 16) ? 16 : min_v);
		// mostly a seeded start; otherwise carry on from the previous odometer
		if ($urandom_range(0, 3) != 0) begin
			for (k = 0; k < lo; k++) send(MODE_LOAD_START, k[7:0], pick_digit());
			send(MODE_BEGIN, $urandom_range(0, 255), {$urandom_range(0, 127), 1'b1});
		end
		if (hold) squeeze = 1'b1;
		for (n = 0; n < count; n++) random_word();
	endtask

	initial begin
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CHARSET_SIZE;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(MODE_LOAD_CHAR, 8'd0, 8'hFF);
		send(MODE_LOAD_CHAR, 8'd255, 8'h00);
		send(MODE_LOAD_CHAR, 8'd1, 8'h41);
		send(MODE_LOAD_CHAR, 8'd2, 8'h80);
		// no run started yet
		send(MODE_NEXT, 8'hFF, 8'hFF);
		// start digit positions past the top are dropped
		send(MODE_LOAD_START, 8'd15, 8'hFF);
		send(MODE_LOAD_START, 8'd16, 8'd1);
		send(MODE_LOAD_START, 8'hFF, 8'd0);

		// whole run through to exhaustion
		configure(2, 1, 2);
		send(MODE_BEGIN, 8'd0, 8'd0);
		repeat (7) send(MODE_NEXT, 8'd0, 8'd0);

		// empty length range
		configure(3, 2, 1);
		send(MODE_BEGIN, 8'd0, 8'd1);
		send(MODE_NEXT, 8'd0, 8'd0);

		// seeded start, then a seed with a digit outside the alphabet
		configure(3, 2, 3);
		send(MODE_LOAD_START, 8'd0, 8'd2);
		send(MODE_LOAD_START, 8'd1, 8'd1);
		send(MODE_BEGIN, 8'd0, 8'd1);
		send(MODE_NEXT, 8'd0, 8'd0);
		send(MODE_NEXT, 8'd0, 8'd0);
		send(MODE_LOAD_START, 8'd1, 8'd3);
		send(MODE_BEGIN, 8'd0, 8'd1);
		send(MODE_NEXT, 8'd0, 8'd0);

		run_phase(2, 1, 3, 24, 1'b0);
		run_phase(1, 1, 16, 24, 1'b0);
		run_phase(0, 0, 31, 18, 1'b0);
		run_phase(4, 16, 16, 22, 1'b1);
		run_phase(5, 2, 3, 22, 1'b0);
		run_phase(3, 3, 2, 12, 1'b0);
		run_phase(16, 5, 6, 20, 1'b0);
		run_phase(256, 1, 16, 24, 1'b0);
		run_phase(511, 2, 20, 22, 1'b0);
		run_phase(3, 1, 2, 24, 1'b0);

		settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
